@@ hw/rtl/mup_pkg.sv @@
// shared types, codes and constants for the midi uart port block
package mup_pkg;

  localparam int QUEUE_DEPTH_DEF = 16;

  typedef enum logic [1:0] {
    REQ_READ  = 2'd0,
    REQ_WRITE = 2'd1,
    REQ_MIDI  = 2'd2,
    REQ_TXRDY = 2'd3
  } req_t;

  localparam logic PORT_DATA = 1'b0;
  localparam logic PORT_CMD  = 1'b1;

  localparam logic [7:0] CMD_ENTER_UART = 8'h3f;
  localparam logic [7:0] CMD_RESET      = 8'hff;
  localparam logic [7:0] ACK_BYTE       = 8'hfe;
  localparam logic [7:0] EMPTY_READ     = 8'hff;

  // status byte bit positions
  localparam int STAT_TX_FULL_BIT  = 6;
  localparam int STAT_RX_EMPTY_BIT = 7;

  // operation requested of one fifo for one transaction
  typedef struct packed {
    logic       clr;
    logic       push;
    logic       pop;
    logic [7:0] wdata;
  } fifo_op_t;

  // fifo status toward the controller, from registered state only
  typedef struct packed {
    logic full;
    logic empty;
    logic one_left;
  } fifo_stat_t;

  // per-transaction result info held until the fifo read data arrives
  typedef struct packed {
    logic       rx_pop;
    logic       tx_pop;
    logic [7:0] rd_const;
    logic       drop;
    logic       irq;
  } res_t;

endpackage

@@ hw/rtl/mup_fifo.sv @@
// byte fifo with clear, push, pop and a registered read port
module mup_fifo import mup_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       en,
  input  fifo_op_t   op,
  output fifo_stat_t stat,
  output logic [7:0] rdata
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int FW = $clog2(DEPTH + 1);
  localparam int SW = FW + 1;

  logic [7:0]    mem [DEPTH];
  logic [AW-1:0] head_r, head_nxt;
  logic [FW-1:0] fill_r, fill_nxt;
  logic [7:0]    rdata_r;

  logic [AW-1:0] base_head;
  logic [FW-1:0] base_fill;
  logic [SW-1:0] wsum;
  logic [AW-1:0] wptr;
  logic          do_push;

  // a clear in the same transaction restarts the fifo before the push
  assign base_head = op.clr ? '0 : head_r;
  assign base_fill = op.clr ? '0 : fill_r;

  assign wsum = SW'(base_head) + SW'(base_fill);
  assign wptr = (wsum >= SW'(DEPTH)) ? AW'(wsum - SW'(DEPTH)) : AW'(wsum);

  assign do_push = op.push && (base_fill != FW'(DEPTH));

  always_comb begin
    head_nxt = base_head;
    fill_nxt = base_fill;
    if (do_push) begin
      fill_nxt = base_fill + FW'(1);
    end else if (op.pop && (base_fill != '0)) begin
      head_nxt = (base_head == AW'(DEPTH - 1)) ? '0 : base_head + AW'(1);
      fill_nxt = base_fill - FW'(1);
    end
  end

  assign stat.full     = (fill_r == FW'(DEPTH));
  assign stat.empty    = (fill_r == '0);
  assign stat.one_left = (fill_r == FW'(1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= '0;
      fill_r <= '0;
    end else if (en) begin
      head_r <= head_nxt;
      fill_r <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en && do_push) begin
      mem[wptr] <= op.wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rdata_r <= mem[head_r];
    end
  end

  assign rdata = rdata_r;

endmodule

@@ hw/rtl/mup_ctrl.sv @@
// request decode, command handling and uart mode flag
module mup_ctrl import mup_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       accept,
  input  logic [1:0] req_type,
  input  logic       port,
  input  logic [7:0] byte_in,
  input  logic       irq_enable,
  input  fifo_stat_t tx_stat,
  input  fifo_stat_t rx_stat,
  output fifo_op_t   tx_op,
  output fifo_op_t   rx_op,
  output res_t       res
);

  logic uart_mode_r, uart_mode_nxt;
  req_t req;

  assign req = req_t'(req_type);

  always_comb begin
    tx_op         = '0;
    rx_op         = '0;
    res           = '0;
    uart_mode_nxt = uart_mode_r;
    unique case (req)
      REQ_READ: begin
        if (port == PORT_DATA) begin
          if (!rx_stat.empty) begin
            rx_op.pop  = 1'b1;
            res.rx_pop = 1'b1;
          end else begin
            res.rd_const = EMPTY_READ;
          end
        end else begin
          res.rd_const[STAT_TX_FULL_BIT]  = tx_stat.full;
          res.rd_const[STAT_RX_EMPTY_BIT] = rx_stat.empty;
        end
      end
      REQ_WRITE: begin
        if (port == PORT_DATA) begin
          if (uart_mode_r) begin
            if (tx_stat.full) begin
              res.drop = 1'b1;
            end else begin
              tx_op.push  = 1'b1;
              tx_op.wdata = byte_in;
            end
          end
        end else if (uart_mode_r) begin
          if (byte_in == CMD_RESET) begin
            tx_op.clr     = 1'b1;
            rx_op.clr     = 1'b1;
            uart_mode_nxt = 1'b0;
          end
        end else begin
          if (byte_in == CMD_RESET) begin
            tx_op.clr = 1'b1;
            rx_op.clr = 1'b1;
          end
          if ((byte_in == CMD_RESET) || !rx_stat.full) begin
            rx_op.push  = 1'b1;
            rx_op.wdata = ACK_BYTE;
          end else begin
            res.drop = 1'b1;
          end
          if (byte_in == CMD_ENTER_UART) begin
            uart_mode_nxt = 1'b1;
          end
        end
      end
      REQ_MIDI: begin
        if (uart_mode_r) begin
          if (rx_stat.full) begin
            res.drop = 1'b1;
          end else begin
            rx_op.push  = 1'b1;
            rx_op.wdata = byte_in;
          end
        end
      end
      REQ_TXRDY: begin
        if (!tx_stat.empty) begin
          tx_op.pop  = 1'b1;
          res.tx_pop = 1'b1;
        end
      end
      default: begin
        res = '0;
      end
    endcase
    // interrupt level reflects the receive fifo after this transaction
    res.irq = irq_enable &&
              (rx_op.push ||
               (!rx_op.clr && !rx_stat.empty && !(rx_op.pop && rx_stat.one_left)));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      uart_mode_r <= 1'b0;
    end else if (accept) begin
      uart_mode_r <= uart_mode_nxt;
    end
  end

endmodule

@@ hw/rtl/midi_uart_port_with_fifos.sv @@
// top level: midi uart port with transmit and receive fifos
// A two-port midi interface in uart mode. Each input transaction is a host
// read, a host write, a received midi byte or a transmitter-ready event, and
// each produces exactly one result transaction carrying the host read byte,
// an optional outgoing midi byte, the interrupt level and a dropped flag.
// The block takes one transaction per cycle unless the result side stalls;
// a result waits in stage 1 for the fifo memories' registered read port,
// then in the output register. Fifo pointers, fill counts and the uart mode
// flag update at the accepting edge, so back-to-back transactions see each
// other's effects. A stall on the result side backs up through one holding
// stage before in_ready drops. irq_enable is written through the cfg port,
// by the user only while no transaction is in flight, unchecked by the block.
module midi_uart_port_with_fifos import mup_pkg::*; #(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  // input channel
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] in_req_type,
  input  logic       in_port,
  input  logic [7:0] in_byte_in,
  // result channel
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_read_data,
  output logic       out_midi_out_valid,
  output logic [7:0] out_midi_out_byte,
  output logic       out_irq_level,
  output logic       out_dropped,
  // configuration
  input  logic       cfg_wr_en,
  input  logic       cfg_wr_data
);

  logic       irq_enable_r;
  logic       accept;
  fifo_op_t   tx_op, rx_op;
  fifo_stat_t tx_stat, rx_stat;
  logic [7:0] tx_rdata, rx_rdata;
  res_t       res;

  // stage 1: decoded result info waiting on the fifo read data
  logic       s1_valid_r;
  res_t       s1_res_r;
  // stage 2: output register
  logic       out_valid_r;
  logic [7:0] read_data_r;
  logic       midi_out_valid_r;
  logic [7:0] midi_out_byte_r;
  logic       irq_level_r;
  logic       dropped_r;
  logic       out_load;

  // stage 1 holds a result and the output register is free or being emptied this cycle
  assign out_load = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || out_load;
  assign accept   = in_valid && in_ready;

  // config register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      irq_enable_r <= 1'b0;
    end else if (cfg_wr_en) begin
      irq_enable_r <= cfg_wr_data;
    end
  end

  mup_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .accept     (accept),
    .req_type   (in_req_type),
    .port       (in_port),
    .byte_in    (in_byte_in),
    .irq_enable (irq_enable_r),
    .tx_stat    (tx_stat),
    .rx_stat    (rx_stat),
    .tx_op      (tx_op),
    .rx_op      (rx_op),
    .res        (res)
  );

  // transmit queue
  mup_fifo #(.DEPTH(QUEUE_DEPTH)) u_tx_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (accept),
    .op    (tx_op),
    .stat  (tx_stat),
    .rdata (tx_rdata)
  );

  // receive queue, also carries the command acknowledge
  mup_fifo #(.DEPTH(QUEUE_DEPTH)) u_rx_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (accept),
    .op    (rx_op),
    .stat  (rx_stat),
    .rdata (rx_rdata)
  );

  // stage 1 control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (accept) begin
      s1_valid_r <= 1'b1;
    end else if (out_load) begin
      s1_valid_r <= 1'b0;
    end
  end

  // stage 1 payload, held while stalled since no new accept happens
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_res_r <= res;
    end
  end

  // stage 2 control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // stage 2 payload: merge fifo read data with the decoded info
  always_ff @(posedge clk) begin
    if (out_load) begin
      read_data_r      <= s1_res_r.rx_pop ? rx_rdata : s1_res_r.rd_const;
      midi_out_valid_r <= s1_res_r.tx_pop;
      midi_out_byte_r  <= s1_res_r.tx_pop ? tx_rdata : 8'h00;
      irq_level_r      <= s1_res_r.irq;
      dropped_r        <= s1_res_r.drop;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_read_data      = read_data_r;
  assign out_midi_out_valid = midi_out_valid_r;
  assign out_midi_out_byte  = midi_out_byte_r;
  assign out_irq_level      = irq_level_r;
  assign out_dropped        = dropped_r;

endmodule
